@@ hw/rtl/assert_macros.svh @@
// Assertion macros used by the checker file of this project.
// Depends on nothing; the checker takes it in by include.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising edge, skipped while reset is high.
`define CHK_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property at every rising edge, reset included.
`define CHK_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hw/rtl/jtag_sct_pkg.sv @@
// Types, codes and sizes of the JTAG shift engine with code tables.
// Used by the controller, the datapath, the top level and the checker.
package jtag_sct_pkg;

  localparam int TABLE_DEPTH    = 16;
  localparam int MAX_SHIFT_BITS = 16;
  localparam int IDX_W          = 4;
  localparam int CNT_W          = 5;
  localparam int WORD_W         = 16;

  // Upper nibble of the table exchange codes
  localparam logic [3:0] CODE_TABLE_A = 4'h4;
  localparam logic [3:0] CODE_TABLE_B = 4'h5;

  typedef enum logic [1:0] {
    OP_EXCHANGE = 2'd0,
    OP_LOAD_A   = 2'd1,
    OP_LOAD_B   = 2'd2,
    OP_RESERVED = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    KIND_BIT    = 2'd0,
    KIND_DONE   = 2'd1,
    KIND_LOADED = 2'd2,
    KIND_ERROR  = 2'd3
  } kind_t;

  typedef struct packed {
    op_t               opcode;
    logic [7:0]        code;
    logic [IDX_W-1:0]  entry_index;
    logic [7:0]        bit_count;
    logic [WORD_W-1:0] tdi_value;
    logic [WORD_W-1:0] tms_value;
    logic [WORD_W-1:0] tdo_levels;
  } item_t;

  typedef struct packed {
    kind_t             kind;
    logic              tms_bit;
    logic              tdi_bit;
    logic [WORD_W-1:0] tdo_word;
    logic              last;
  } result_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic  load;
    logic  write_a;
    logic  write_b;
    logic  step;
    kind_t kind;
  } ctrl_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic shift_ok;
    logic load_a_ok;
    logic load_b_ok;
    logic zero_bits;
    logic last_bit;
  } stat_t;

endpackage

@@ hw/rtl/jtag_shift_with_code_tables_unit.sv @@
// Top level of the JTAG shift engine with two code tables.
// Depends on jtag_sct_pkg, jtag_sct_ctrl and jtag_sct_dp.
//
// Use:
//   Input channel: drive item and raise start; the item is taken at the
//   rising edge where start is high and busy is low.
//   Result channel: every result beat is on result for one cycle with
//   strobe high; the receiver must take it then, it cannot stall.
//   An exchange of n bits (n = 0..16) gives n bit beats, one per cycle,
//   then a done beat with the TDO capture word and last set. A load or an
//   erroneous item gives one beat with last set.
// Latency: the first beat appears in the cycle after the accepting edge.
// Throughput: busy stays high from the accepting edge through the last
//   beat, so a new item is taken only once the last one is through, for
//   exchanges, loads and errors alike. The shift register steps one bit a
//   cycle.
// Reset: synchronous, active high; clears the controller to idle and
//   all table entries to zero, so table codes run zero-bit exchanges.
module jtag_shift_with_code_tables_unit (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  jtag_sct_pkg::item_t   item,
  output logic                  strobe,
  output jtag_sct_pkg::result_t result
);

  jtag_sct_pkg::ctrl_t ctrl;
  jtag_sct_pkg::stat_t stat;

  // Sequence each item
  jtag_sct_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .stat   (stat),
    .busy   (busy),
    .strobe (strobe),
    .ctrl   (ctrl)
  );

  // Hold tables and shift state
  jtag_sct_dp u_dp (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .ctrl   (ctrl),
    .stat   (stat),
    .result (result)
  );

endmodule

@@ hw/rtl/jtag_sct_dp.sv @@
// Datapath: code tables, item decode, TDI/TMS shift registers and TDO capture.
// Depends on jtag_sct_pkg; driven by jtag_sct_ctrl.
module jtag_sct_dp (
  input  logic                clk,
  input  logic                rst,
  input  jtag_sct_pkg::item_t item,
  input  jtag_sct_pkg::ctrl_t ctrl,
  output jtag_sct_pkg::stat_t stat,
  output jtag_sct_pkg::result_t result
);

  logic [jtag_sct_pkg::WORD_W-1:0] table_a_tdi  [jtag_sct_pkg::TABLE_DEPTH];
  logic [jtag_sct_pkg::WORD_W-1:0] table_a_tms  [jtag_sct_pkg::TABLE_DEPTH];
  logic [jtag_sct_pkg::CNT_W-1:0]  table_a_bits [jtag_sct_pkg::TABLE_DEPTH];
  logic [jtag_sct_pkg::WORD_W-1:0] table_b_tms  [jtag_sct_pkg::TABLE_DEPTH];
  logic [jtag_sct_pkg::CNT_W-1:0]  table_b_bits [jtag_sct_pkg::TABLE_DEPTH];

  logic [jtag_sct_pkg::CNT_W-1:0]  count;
  logic [jtag_sct_pkg::WORD_W-1:0] tdi_sr;
  logic [jtag_sct_pkg::WORD_W-1:0] tms_sr;
  logic [jtag_sct_pkg::WORD_W-1:0] tdo_sr;
  logic [jtag_sct_pkg::WORD_W-1:0] cap;

  logic [jtag_sct_pkg::IDX_W-1:0]  entry;
  logic                            raw_ok;
  logic                            entry_ok;
  logic                            is_a;
  logic                            is_b;
  logic                            load_ok;
  logic [jtag_sct_pkg::CNT_W-1:0]  nbits;
  logic [jtag_sct_pkg::WORD_W-1:0] tdi_sel;
  logic [jtag_sct_pkg::WORD_W-1:0] tms_sel;

  // Decode the offered item and pick its bit count and shift words
  always_comb begin
    entry    = item.code[jtag_sct_pkg::IDX_W-1:0];
    raw_ok   = item.code <= 8'(jtag_sct_pkg::MAX_SHIFT_BITS);
    entry_ok = {1'b0, entry} < 5'(jtag_sct_pkg::TABLE_DEPTH);
    is_a     = item.code[7:4] == jtag_sct_pkg::CODE_TABLE_A;
    is_b     = item.code[7:4] == jtag_sct_pkg::CODE_TABLE_B;
    load_ok  = ({1'b0, item.entry_index} < 5'(jtag_sct_pkg::TABLE_DEPTH)) &&
               (item.bit_count <= 8'(jtag_sct_pkg::MAX_SHIFT_BITS));
    nbits    = item.code[jtag_sct_pkg::CNT_W-1:0];
    tdi_sel  = item.tdi_value;
    tms_sel  = item.tms_value;
    if (!raw_ok && is_a) begin
      nbits   = table_a_bits[entry];
      tdi_sel = table_a_tdi[entry];
      tms_sel = table_a_tms[entry];
    end else if (!raw_ok && is_b) begin
      nbits   = table_b_bits[entry];
      tms_sel = table_b_tms[entry];
    end
    stat.shift_ok  = (item.opcode == jtag_sct_pkg::OP_EXCHANGE) &&
                     (raw_ok || ((is_a || is_b) && entry_ok));
    stat.load_a_ok = (item.opcode == jtag_sct_pkg::OP_LOAD_A) && load_ok;
    stat.load_b_ok = (item.opcode == jtag_sct_pkg::OP_LOAD_B) && load_ok;
    stat.zero_bits = nbits == '0;
    stat.last_bit  = count == jtag_sct_pkg::CNT_W'(1);
  end

  // Write one table entry per load beat
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < jtag_sct_pkg::TABLE_DEPTH; i++) begin
        table_a_tdi[i]  <= '0;
        table_a_tms[i]  <= '0;
        table_a_bits[i] <= '0;
        table_b_tms[i]  <= '0;
        table_b_bits[i] <= '0;
      end
    end else if (ctrl.write_a) begin
      table_a_tdi[item.entry_index]  <= item.tdi_value;
      table_a_tms[item.entry_index]  <= item.tms_value;
      table_a_bits[item.entry_index] <= item.bit_count[jtag_sct_pkg::CNT_W-1:0];
    end else if (ctrl.write_b) begin
      table_b_tms[item.entry_index]  <= item.tms_value;
      table_b_bits[item.entry_index] <= item.bit_count[jtag_sct_pkg::CNT_W-1:0];
    end
  end

  // Load the shift words on accept, advance one bit per step
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      count  <= nbits;
      tdi_sr <= tdi_sel;
      tms_sr <= tms_sel;
      tdo_sr <= item.tdo_levels;
      cap    <= '0;
    end else if (ctrl.step) begin
      count  <= count - jtag_sct_pkg::CNT_W'(1);
      tdi_sr <= tdi_sr >> 1;
      tms_sr <= tms_sr >> 1;
      tdo_sr <= tdo_sr >> 1;
      cap    <= {tdo_sr[0], cap[jtag_sct_pkg::WORD_W-1:1]};
    end
  end

  // Form the result beat for the kind the controller shows
  always_comb begin
    result.kind     = ctrl.kind;
    result.tms_bit  = (ctrl.kind == jtag_sct_pkg::KIND_BIT) ? tms_sr[0] : 1'b0;
    result.tdi_bit  = (ctrl.kind == jtag_sct_pkg::KIND_BIT) ? tdi_sr[0] : 1'b0;
    result.tdo_word = (ctrl.kind == jtag_sct_pkg::KIND_DONE) ? cap : '0;
    result.last     = ctrl.kind != jtag_sct_pkg::KIND_BIT;
  end

endmodule

@@ hw/rtl/jtag_sct_ctrl.sv @@
// Controller state machine of the JTAG shift engine with code tables.
// Depends on jtag_sct_pkg; commands jtag_sct_dp.
module jtag_sct_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  jtag_sct_pkg::stat_t stat,
  output logic                busy,
  output logic                strobe,
  output jtag_sct_pkg::ctrl_t ctrl
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SHIFT,
    ST_DONE,
    ST_SINGLE
  } state_t;

  state_t                    state;
  state_t                    state_next;
  jtag_sct_pkg::kind_t       single_kind;
  jtag_sct_pkg::kind_t       single_kind_next;

  // Pick the next state and the commands for this cycle
  always_comb begin
    state_next       = state;
    single_kind_next = single_kind;
    ctrl             = '0;
    ctrl.kind        = jtag_sct_pkg::KIND_BIT;
    strobe           = 1'b0;
    case (state)
      ST_IDLE: begin
        if (start) begin
          if (stat.shift_ok) begin
            ctrl.load  = 1'b1;
            state_next = stat.zero_bits ? ST_DONE : ST_SHIFT;
          end else if (stat.load_a_ok) begin
            ctrl.write_a     = 1'b1;
            single_kind_next = jtag_sct_pkg::KIND_LOADED;
            state_next       = ST_SINGLE;
          end else if (stat.load_b_ok) begin
            ctrl.write_b     = 1'b1;
            single_kind_next = jtag_sct_pkg::KIND_LOADED;
            state_next       = ST_SINGLE;
          end else begin
            single_kind_next = jtag_sct_pkg::KIND_ERROR;
            state_next       = ST_SINGLE;
          end
        end
      end
      ST_SHIFT: begin
        strobe    = 1'b1;
        ctrl.step = 1'b1;
        ctrl.kind = jtag_sct_pkg::KIND_BIT;
        if (stat.last_bit) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        strobe     = 1'b1;
        ctrl.kind  = jtag_sct_pkg::KIND_DONE;
        state_next = ST_IDLE;
      end
      ST_SINGLE: begin
        strobe     = 1'b1;
        ctrl.kind  = single_kind;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign busy = state != ST_IDLE;

  // Hold state and the kind of a single-beat result
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      single_kind <= jtag_sct_pkg::KIND_ERROR;
    end else begin
      state       <= state_next;
      single_kind <= single_kind_next;
    end
  end

endmodule

@@ hw/rtl/jtag_sct_chk.sv @@
// Port-level checker for jtag_shift_with_code_tables_unit, bound to it below.
// Depends on jtag_sct_pkg and assert_macros.svh.
`include "assert_macros.svh"

module jtag_sct_chk (
  input logic                  clk,
  input logic                  rst,
  input logic                  start,
  input logic                  busy,
  input jtag_sct_pkg::item_t   item,
  input logic                  strobe,
  input jtag_sct_pkg::result_t result
);

  logic bit_beat;

  assign bit_beat = strobe && (result.kind == jtag_sct_pkg::KIND_BIT);

  // An accepted item shows its first beat in the next cycle
  `CHK_ASSERT(a_accept_beat, clk, rst, (start && !busy) |=> strobe, "no beat after accept")
  // A bit beat is always followed by another beat of the same item
  `CHK_ASSERT(a_bit_follow, clk, rst, bit_beat |=> strobe, "gap after a bit beat")
  // The final beat of an item is followed by an idle cycle
  `CHK_ASSERT(a_last_gap, clk, rst, (strobe && result.last) |=> !strobe, "beat after last")
  // Only non-bit beats close an item
  `CHK_ASSERT(a_last_kind, clk, rst, strobe |-> (result.last == !bit_beat), "last mismatch")

endmodule

bind jtag_shift_with_code_tables_unit jtag_sct_chk u_chk (.*);
